### sv/triangle_tangent_calc_macros.svh
// Assertion macros shared by the triangle tangent calculator modules.
`ifndef TRIANGLE_TANGENT_CALC_MACROS_SVH
`define TRIANGLE_TANGENT_CALC_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define TTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("triangle tangent check failed (same cycle)");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define TTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("triangle tangent check failed (next cycle)");
`else
`define TTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### sv/ttc_pkg.sv
// Shared types and constants of the triangle tangent calculator.
`default_nettype none
`timescale 1ns / 1ps
package ttc_pkg;

    localparam int COORD_W  = 32;              // Q16.16 coordinate
    localparam int DELTA_W  = COORD_W + 1;     // edge or UV delta, Q17.16
    localparam int PROD_W   = 2 * DELTA_W;     // exact product, Q34.32
    localparam int WIDE_W   = PROD_W + 1;      // determinant or numerator, Q35.32
    localparam int FRAC_W   = 16;              // fraction bits of the result
    localparam int QUO_W    = COORD_W;         // quotient bits formed by the divider
    localparam int ITER_W   = $clog2(QUO_W);
    localparam int IN_W     = 5 * COORD_W;
    localparam int OUT_W    = 3 * COORD_W;
    localparam int USER_W   = 2;

    localparam logic [COORD_W-1:0] SAT_POS = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] SAT_NEG = {1'b1, {(COORD_W-1){1'b0}}};

    // Slot codes: which difference of products the multiply pair is forming.
    localparam logic [1:0] SLOT_DET = 2'd0;
    localparam logic [1:0] SLOT_X   = 2'd1;
    localparam logic [1:0] SLOT_Y   = 2'd2;
    localparam logic [1:0] SLOT_Z   = 2'd3;

    typedef struct packed {
        logic       take_last;  // a third corner may be taken now
        logic       mul_en;     // form the product pair for slot
        logic       sub_en;     // store the difference of the pair in slot
        logic [1:0] slot;
        logic       abs_en;     // split determinant and numerators into sign and magnitude
        logic       init_en;    // load the dividers
        logic       step_en;    // one restoring division step
        logic       fin_en;     // load the output register
    } t_cmd;

    typedef struct packed {
        logic start;     // third corner accepted this cycle
        logic det_zero;  // stored determinant is zero
        logic out_free;  // output register can take a result
    } t_stat;

endpackage
`default_nettype wire

### sv/ttc_div_lane.sv
// One restoring divider lane: sign, magnitude, quotient and saturation of one component.
`default_nettype none
`timescale 1ns / 1ps
module ttc_div_lane (
    input  wire logic                         i_clk,
    input  wire ttc_pkg::t_cmd                i_cmd,
    input  wire logic [ttc_pkg::WIDE_W-1:0]   i_num,
    input  wire logic                         i_det_sign,
    input  wire logic [ttc_pkg::WIDE_W-1:0]   i_det_mag,
    output logic      [ttc_pkg::COORD_W-1:0]  o_comp,
    output logic                              o_sat
);
    import ttc_pkg::*;

    logic [WIDE_W-1:0]  r_mag;
    logic               r_neg;
    logic [WIDE_W-1:0]  r_rem;
    logic [QUO_W-1:0]   r_q;
    logic               r_ovf;

    logic [WIDE_W-1:0]  n_mag;
    logic [WIDE_W-1:0]  n_top;
    logic [WIDE_W:0]    n_trial;
    logic [WIDE_W:0]    n_diff;
    logic               n_ge;

    assign n_mag   = i_num[WIDE_W-1] ? (~i_num + 1'b1) : i_num;
    assign n_top   = {{FRAC_W{1'b0}}, r_mag[WIDE_W-1:FRAC_W]};
    assign n_trial = {r_rem, r_q[QUO_W-1]};
    assign n_diff  = n_trial - {1'b0, i_det_mag};
    assign n_ge    = (n_trial >= {1'b0, i_det_mag});

    always_ff @(posedge i_clk) begin
        if (i_cmd.abs_en) begin
            r_mag <= n_mag;
            r_neg <= i_num[WIDE_W-1] ^ i_det_sign;
        end
        if (i_cmd.init_en) begin
            // The quotient needs more than QUO_W bits when the upper dividend
            // part already reaches the divisor.
            r_rem <= n_top;
            r_ovf <= (n_top >= i_det_mag);
            r_q   <= {r_mag[FRAC_W-1:0], {(QUO_W-FRAC_W){1'b0}}};
        end else if (i_cmd.step_en) begin
            r_rem <= n_ge ? n_diff[WIDE_W-1:0] : n_trial[WIDE_W-1:0];
            r_q   <= {r_q[QUO_W-2:0], n_ge};
        end
    end

    always_comb begin
        if (r_neg) begin
            o_sat  = r_ovf | (r_q[QUO_W-1] & (|r_q[QUO_W-2:0]));
            o_comp = o_sat ? SAT_NEG : (~r_q + 1'b1);
        end else begin
            o_sat  = r_ovf | r_q[QUO_W-1];
            o_comp = o_sat ? SAT_POS : r_q;
        end
    end

endmodule
`default_nettype wire

### sv/ttc_dpath.sv
// Datapath: corner capture, deltas, product pair, sign split, three divider lanes, output register.
`default_nettype none
`timescale 1ns / 1ps
`include "triangle_tangent_calc_macros.svh"
module ttc_dpath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ttc_pkg::t_cmd                i_cmd,
    output ttc_pkg::t_stat                    o_stat,
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    input  wire logic [ttc_pkg::IN_W-1:0]     i_s_tdata,
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output logic      [ttc_pkg::OUT_W-1:0]    o_m_tdata,
    output logic      [ttc_pkg::USER_W-1:0]   o_m_tuser
);
    import ttc_pkg::*;

    localparam logic [1:0] CORNER_0 = 2'd0;
    localparam logic [1:0] CORNER_1 = 2'd1;
    localparam logic [1:0] CORNER_2 = 2'd2;

    function automatic logic [DELTA_W-1:0] sub_ext(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        return {a[COORD_W-1], a} - {b[COORD_W-1], b};
    endfunction

    logic [1:0]               r_count;
    logic [COORD_W-1:0]       r_c0_pos [3];
    logic [COORD_W-1:0]       r_c1_pos [3];
    logic [COORD_W-1:0]       r_c0_uv  [2];
    logic [COORD_W-1:0]       r_c1_uv  [2];

    logic signed [DELTA_W-1:0] r_e1 [3];
    logic signed [DELTA_W-1:0] r_e2 [3];
    logic signed [DELTA_W-1:0] r_du1, r_dv1, r_du2, r_dv2;

    logic signed [PROD_W-1:0]  r_pa, r_pb;
    logic [WIDE_W-1:0]         r_det;
    logic [WIDE_W-1:0]         r_num [3];
    logic [WIDE_W-1:0]         r_det_mag;

    logic                      r_out_valid;
    logic [COORD_W-1:0]        r_out_t [3];
    logic                      r_out_deg;
    logic                      r_out_sat;

    logic [COORD_W-1:0]        in_pos [3];
    logic [COORD_W-1:0]        in_uv  [2];
    logic                      in_acc;
    logic signed [DELTA_W-1:0] n_sel_a, n_sel_b;
    logic [COORD_W-1:0]        lane_comp [3];
    logic [2:0]                lane_sat;
    logic                      det_zero;

    assign in_pos[0] = i_s_tdata[0*COORD_W +: COORD_W];
    assign in_pos[1] = i_s_tdata[1*COORD_W +: COORD_W];
    assign in_pos[2] = i_s_tdata[2*COORD_W +: COORD_W];
    assign in_uv[0]  = i_s_tdata[3*COORD_W +: COORD_W];
    assign in_uv[1]  = i_s_tdata[4*COORD_W +: COORD_W];

    assign o_s_tready = (r_count != CORNER_2) | i_cmd.take_last;
    assign in_acc     = i_s_tvalid & o_s_tready;
    assign det_zero   = (r_det == '0);

    assign o_stat.start    = in_acc & (r_count == CORNER_2);
    assign o_stat.det_zero = det_zero;
    assign o_stat.out_free = ~r_out_valid | i_m_tready;

    // Corner counter and held corners.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CORNER_0;
        end else if (in_acc) begin
            priority if (r_count == CORNER_2) begin
                r_count <= CORNER_0;
            end else if (r_count == CORNER_1) begin
                r_count <= CORNER_2;
            end else begin
                r_count <= CORNER_1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            priority if (r_count == CORNER_2) begin
                for (int i = 0; i < 3; i++) begin
                    r_e1[i] <= sub_ext(r_c1_pos[i], r_c0_pos[i]);
                    r_e2[i] <= sub_ext(in_pos[i], r_c0_pos[i]);
                end
                r_du1 <= sub_ext(r_c1_uv[0], r_c0_uv[0]);
                r_dv1 <= sub_ext(r_c1_uv[1], r_c0_uv[1]);
                r_du2 <= sub_ext(in_uv[0], r_c0_uv[0]);
                r_dv2 <= sub_ext(in_uv[1], r_c0_uv[1]);
            end else if (r_count == CORNER_1) begin
                for (int i = 0; i < 3; i++) begin
                    r_c1_pos[i] <= in_pos[i];
                end
                r_c1_uv[0] <= in_uv[0];
                r_c1_uv[1] <= in_uv[1];
            end else begin
                for (int i = 0; i < 3; i++) begin
                    r_c0_pos[i] <= in_pos[i];
                end
                r_c0_uv[0] <= in_uv[0];
                r_c0_uv[1] <= in_uv[1];
            end
        end
    end

    // The pair is always dV2 * a - dV1 * b; only a and b change with the slot.
    always_comb begin
        unique case (i_cmd.slot)
            SLOT_DET: begin
                n_sel_a = r_du1;
                n_sel_b = r_du2;
            end
            SLOT_X: begin
                n_sel_a = r_e1[0];
                n_sel_b = r_e2[0];
            end
            SLOT_Y: begin
                n_sel_a = r_e1[1];
                n_sel_b = r_e2[1];
            end
            SLOT_Z: begin
                n_sel_a = r_e1[2];
                n_sel_b = r_e2[2];
            end
            default: begin
                n_sel_a = r_du1;
                n_sel_b = r_du2;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_pa <= r_dv2 * n_sel_a;
            r_pb <= r_dv1 * n_sel_b;
        end
        if (i_cmd.sub_en) begin
            unique case (i_cmd.slot)
                SLOT_DET: r_det    <= {r_pa[PROD_W-1], r_pa} - {r_pb[PROD_W-1], r_pb};
                SLOT_X:   r_num[0] <= {r_pa[PROD_W-1], r_pa} - {r_pb[PROD_W-1], r_pb};
                SLOT_Y:   r_num[1] <= {r_pa[PROD_W-1], r_pa} - {r_pb[PROD_W-1], r_pb};
                SLOT_Z:   r_num[2] <= {r_pa[PROD_W-1], r_pa} - {r_pb[PROD_W-1], r_pb};
                default:  r_det    <= {r_pa[PROD_W-1], r_pa} - {r_pb[PROD_W-1], r_pb};
            endcase
        end
        if (i_cmd.abs_en) begin
            r_det_mag <= r_det[WIDE_W-1] ? (~r_det + 1'b1) : r_det;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        ttc_div_lane u_lane (
            .i_clk      (i_clk),
            .i_cmd      (i_cmd),
            .i_num      (r_num[g]),
            .i_det_sign (r_det[WIDE_W-1]),
            .i_det_mag  (r_det_mag),
            .o_comp     (lane_comp[g]),
            .o_sat      (lane_sat[g])
        );
    end

    // Output register: holds one finished result while the next triangle is worked on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin_en) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_en) begin
            for (int i = 0; i < 3; i++) begin
                r_out_t[i] <= det_zero ? '0 : lane_comp[i];
            end
            r_out_deg <= det_zero;
            r_out_sat <= ~det_zero & (|lane_sat);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_t[2], r_out_t[1], r_out_t[0]};
    assign o_m_tuser  = {r_out_sat, r_out_deg};

    `TTC_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count == CORNER_0 || r_count == CORNER_1 || r_count == CORNER_2)
    `TTC_ASSERT_NXT(a_third_wraps, i_clk, i_rst_n, in_acc && r_count == CORNER_2, r_count == CORNER_0)
    `TTC_ASSERT_IMP(a_degen_zero, i_clk, i_rst_n, r_out_valid && r_out_deg, r_out_t[0] == '0 && r_out_t[1] == '0 && r_out_t[2] == '0 && !r_out_sat)

endmodule
`default_nettype wire

### sv/ttc_ctrl.sv
// Controller: sequences the product pairs, the sign split, the division steps and the result load.
`default_nettype none
`timescale 1ns / 1ps
`include "triangle_tangent_calc_macros.svh"
module ttc_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ttc_pkg::t_stat  i_stat,
    output ttc_pkg::t_cmd        o_cmd
);
    import ttc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUB,
        S_ABS,
        S_INIT,
        S_DIV,
        S_FIN
    } t_state;

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(QUO_W - 1);

    t_state             r_state;
    logic [1:0]         r_slot;
    logic [ITER_W-1:0]  r_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= SLOT_DET;
            r_iter  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_stat.start) begin
                        r_state <= S_MUL;
                        r_slot  <= SLOT_DET;
                    end
                end
                S_MUL: begin
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    if (r_slot == SLOT_Z) begin
                        r_state <= S_ABS;
                    end else begin
                        r_slot  <= r_slot + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_ABS: begin
                    r_state <= i_stat.det_zero ? S_FIN : S_INIT;
                end
                S_INIT: begin
                    r_iter  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_iter == ITER_LAST) begin
                        r_state <= S_FIN;
                    end else begin
                        r_iter <= r_iter + 1'b1;
                    end
                end
                S_FIN: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.slot      = r_slot;
        o_cmd.take_last = (r_state == S_IDLE);
        o_cmd.mul_en    = (r_state == S_MUL);
        o_cmd.sub_en    = (r_state == S_SUB);
        o_cmd.abs_en    = (r_state == S_ABS);
        o_cmd.init_en   = (r_state == S_INIT);
        o_cmd.step_en   = (r_state == S_DIV);
        o_cmd.fin_en    = (r_state == S_FIN) & i_stat.out_free;
    end

    `TTC_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_stat.start, r_state == S_IDLE)
    `TTC_ASSERT_NXT(a_start_mul, i_clk, i_rst_n, i_stat.start, r_state == S_MUL && r_slot == SLOT_DET)
    `TTC_ASSERT_NXT(a_degen_skip, i_clk, i_rst_n, r_state == S_ABS && i_stat.det_zero, r_state == S_FIN)
    `TTC_ASSERT_NXT(a_div_done, i_clk, i_rst_n, r_state == S_DIV && r_iter == ITER_LAST, r_state == S_FIN)

endmodule
`default_nettype wire

### sv/triangle_tangent_calc.sv
// Top level of the per-triangle UV tangent calculator.
//
//  Channel  Direction  Transaction payload
//  -------  ---------  ---------------------------------------------------------
//  s        in         one triangle corner: position x, y, z and texture u, v
//  m        out        one face tangent x, y, z with degenerate/saturated flags
//
// A triangle's first two corners are held at once, one transaction per cycle,
// even while the previous triangle is still being worked on. The third corner
// is taken only while the controller is idle. It then forms the determinant and
// three numerators on one pair of 33x33 multipliers, a multiply state and a
// subtract state per slot, then splits the signs, loads the dividers, runs 32
// restoring division steps (three lanes in parallel, one quotient bit each per
// cycle) and loads the output register once it is free. When the determinant
// is zero, the divider load and the division are skipped. The 32 division
// steps make up most of the work per triangle.
// Reset is synchronous and active low; it clears the corner count, the
// controller and the output valid. A stalled output holds its transaction and
// the next triangle may finish its work behind it before the block waits.
`default_nettype none
`timescale 1ns / 1ps
module triangle_tangent_calc (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Corner input stream.
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    // tdata, low bit up: pos_x[31:0], pos_y[63:32], pos_z[95:64],
    // tex_u[127:96], tex_v[159:128], all signed Q16.16.
    input  wire logic [ttc_pkg::IN_W-1:0]     i_s_tdata,
    // Tangent output stream.
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    // tdata, low bit up: tangent_x[31:0], tangent_y[63:32], tangent_z[95:64],
    // all signed Q16.16.
    output logic      [ttc_pkg::OUT_W-1:0]    o_m_tdata,
    // tuser, low bit up: degenerate[0], saturated[1].
    output logic      [ttc_pkg::USER_W-1:0]   o_m_tuser
);
    import ttc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // The controller only steps through the work of one triangle; all arithmetic
    // on the data and all data storage sit in the datapath.
    ttc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    ttc_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
`default_nettype wire
